@@ hdl/ps2_host_bit_engine_unit_macros.svh @@
// Assertion helpers for the bit engine core.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef PS2_HOST_BIT_ENGINE_UNIT_MACROS_SVH
`define PS2_HOST_BIT_ENGINE_UNIT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define PS2HBE_ASSERT(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("ps2hbe assertion failed");

// A condition that holds in the cycle after a trigger.
`define PS2HBE_ASSERT_NEXT(name, trig, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("ps2hbe assertion failed");

`endif

@@ hdl/ps2hbe_pkg.sv @@
package ps2hbe_pkg;

  localparam int unsigned EdgeW = 4;
  localparam int unsigned ByteW = 8;

  typedef logic [EdgeW-1:0] edge_t;
  typedef logic [ByteW-1:0] byte_t;

  // Edge numbers within one frame.
  localparam edge_t LastEdge   = edge_t'(10);
  localparam edge_t RxFirst    = edge_t'(2);
  localparam edge_t RxLast     = edge_t'(9);
  localparam edge_t TxFirst    = edge_t'(1);
  localparam edge_t TxLast     = edge_t'(8);
  localparam edge_t ParityEdge = edge_t'(9);
  localparam edge_t WrapEdge   = edge_t'(0);

  // Item codes.
  localparam logic ModeEdge = 1'b0;
  localparam logic ModeSend = 1'b1;

  typedef struct packed {
    logic  mode;
    logic  data_bit;
    byte_t command;
  } item_t;

  typedef struct packed {
    logic  data_drive;
    logic  byte_valid;
    byte_t rx_byte;
    logic  tx_done;
    logic  transmitting;
  } result_t;

  // Odd parity: one when the byte holds an even number of ones.
  function automatic logic odd_parity(byte_t v);
    return ~(^v);
  endfunction

endpackage

@@ hdl/ps2hbe_in_stage.sv @@
module ps2hbe_in_stage import ps2hbe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  input  logic  drain_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  // The register can take a new item when empty or when it drains this cycle.
  assign in_ready_o = !valid_q || drain_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ hdl/ps2hbe_core.sv @@
`include "ps2_host_bit_engine_unit_macros.svh"

module ps2hbe_core import ps2hbe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    adv_i,
  input  item_t   item_i,
  output result_t result_o
);

  edge_t edge_q, edge_d, cnt;
  byte_t shift_q, shift_d;
  logic  parity_q, parity_d;
  logic  tx_q, tx_d;
  logic  lvl_q, lvl_d;
  logic  byte_valid;
  byte_t rx_byte;
  logic  tx_done;

  always_comb begin
    edge_d     = edge_q;
    shift_d    = shift_q;
    parity_d   = parity_q;
    tx_d       = tx_q;
    lvl_d      = lvl_q;
    byte_valid = 1'b0;
    rx_byte    = '0;
    tx_done    = 1'b0;
    cnt        = (edge_q >= LastEdge) ? WrapEdge : edge_q + edge_t'(1);

    if (item_i.mode == ModeSend) begin
      // A send request restarts the frame as a transmit with the start bit low.
      parity_d = odd_parity(item_i.command);
      shift_d  = item_i.command;
      edge_d   = WrapEdge;
      lvl_d    = 1'b0;
      tx_d     = 1'b1;
    end else begin
      edge_d = cnt;
      if (!tx_q) begin
        if (cnt inside {[RxFirst:RxLast]}) begin
          shift_d = {item_i.data_bit, shift_q[ByteW-1:1]};
        end else if (cnt == WrapEdge) begin
          byte_valid = 1'b1;
          rx_byte    = shift_q;
        end
      end else begin
        if (cnt inside {[TxFirst:TxLast]}) begin
          lvl_d   = shift_q[0];
          shift_d = {1'b0, shift_q[ByteW-1:1]};
        end else if (cnt == ParityEdge) begin
          lvl_d = parity_q;
        end else if (cnt == LastEdge) begin
          lvl_d = 1'b1;
        end else if (cnt == WrapEdge) begin
          lvl_d   = 1'b1;
          tx_d    = 1'b0;
          tx_done = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q   <= '0;
      shift_q  <= '0;
      parity_q <= 1'b0;
      tx_q     <= 1'b0;
      lvl_q    <= 1'b1;
    end else if (adv_i) begin
      edge_q   <= edge_d;
      shift_q  <= shift_d;
      parity_q <= parity_d;
      tx_q     <= tx_d;
      lvl_q    <= lvl_d;
    end
  end

  assign result_o.data_drive   = lvl_d;
  assign result_o.byte_valid   = byte_valid;
  assign result_o.rx_byte      = rx_byte;
  assign result_o.tx_done      = tx_done;
  assign result_o.transmitting = tx_d;

  `PS2HBE_ASSERT(a_edge_in_range, edge_q <= LastEdge)
  `PS2HBE_ASSERT(a_line_released_in_rx, tx_q || lvl_q)
  `PS2HBE_ASSERT(a_rx_tx_exclusive, !(result_o.byte_valid && result_o.tx_done))
  `PS2HBE_ASSERT_NEXT(a_send_starts_frame, adv_i && (item_i.mode == ModeSend),
                      tx_q && !lvl_q && (edge_q == WrapEdge))

endmodule

@@ hdl/ps2hbe_out_stage.sv @@
module ps2hbe_out_stage import ps2hbe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    src_valid_i,
  output logic    adv_o,
  input  result_t result_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  // A result moves in when the register is empty or is being emptied now.
  assign adv_o   = src_valid_i && (!valid_q || out_ready_i);
  assign valid_d = adv_o ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

@@ hdl/ps2_host_bit_engine_unit.sv @@
// Path: an input transfer loads the input register, and the result register loads the result
// once it is empty or being emptied; the engine state updates as the item leaves the input
// register.
// Throughput: one item per clock cycle while the result side takes each result.
// Reset (rst_ni low, asynchronous): both stages empty, edge counter, shift register and
// parity cleared, receive mode, data line released high.
module ps2_host_bit_engine_unit import ps2hbe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  // Input channel.
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  mode_i,
  input  logic  data_bit_i,
  input  byte_t command_i,
  // Result channel.
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output logic  data_drive_o,
  output logic  byte_valid_o,
  output byte_t rx_byte_o,
  output logic  tx_done_o,
  output logic  transmitting_o
);

  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    adv;
  result_t core_result;
  result_t out_result;

  // Pack the input ports into one item.
  assign in_item.mode     = mode_i;
  assign in_item.data_bit = data_bit_i;
  assign in_item.command  = command_i;

  // The input register holds one accepted transfer until the result register can
  // take its result, so the input side can take one more transfer while a result waits.
  ps2hbe_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .drain_i    (adv),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  // The frame state machine: edge counter, shift register, parity and line level.
  // Its state commits only in the cycle the item advances into the result register.
  ps2hbe_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .item_i   (stage_item),
    .result_o (core_result)
  );

  // The result register presents each result until the consumer takes it.
  ps2hbe_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .src_valid_i (stage_valid),
    .adv_o       (adv),
    .result_i    (core_result),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign data_drive_o   = out_result.data_drive;
  assign byte_valid_o   = out_result.byte_valid;
  assign rx_byte_o      = out_result.rx_byte;
  assign tx_done_o      = out_result.tx_done;
  assign transmitting_o = out_result.transmitting;

endmodule

@@ tb/ps2_host_bit_engine_unit_test.sv @@
`timescale 1ns / 1ps

module ps2_host_bit_engine_unit_test import ps2hbe_pkg::*; ();

  localparam int unsigned TargetItems = 750;
  localparam int unsigned QuietItems  = 650;
  localparam int unsigned LongHold    = 100;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned FrameEdges  = 11;

  // Tracks the line state the engine should have and queues the expected
  // outcome of every accepted transfer.
  class bit_engine_tracker;
    edge_t       edge_cnt;
    byte_t       frame;
    logic        parity;
    logic        sending;
    logic        line_level;
    result_t     outcomes[$];
    int unsigned mismatches;
    int unsigned bytes_seen;
    int unsigned sends_done;
    int unsigned results_seen;

    function new();
      edge_cnt     = WrapEdge;
      frame        = '0;
      parity       = 1'b0;
      sending      = 1'b0;
      line_level   = 1'b1;
      mismatches   = 0;
      bytes_seen   = 0;
      sends_done   = 0;
      results_seen = 0;
    endfunction

    // One when the byte holds an even number of ones.
    static function logic odd_of(byte_t v);
      logic acc;
      acc = 1'b1;
      for (int i = 0; i < ByteW; i++) begin
        acc = acc ^ v[i];
      end
      return acc;
    endfunction

    function void note_transfer(logic mode, logic data_bit, byte_t command);
      result_t r;
      edge_t   nxt;
      r = '0;
      if (mode == ModeSend) begin
        parity     = odd_of(command);
        frame      = command;
        edge_cnt   = WrapEdge;
        line_level = 1'b0;
        sending    = 1'b1;
      end else begin
        nxt      = (edge_cnt >= LastEdge) ? WrapEdge : edge_t'(edge_cnt + 1'b1);
        edge_cnt = nxt;
        if (!sending) begin
          if (nxt >= RxFirst && nxt <= RxLast) begin
            frame = {data_bit, frame[ByteW-1:1]};
          end else if (nxt == WrapEdge) begin
            r.byte_valid = 1'b1;
            r.rx_byte    = frame;
          end
        end else begin
          if (nxt >= TxFirst && nxt <= TxLast) begin
            line_level = frame[0];
            frame      = frame >> 1;
          end else if (nxt == ParityEdge) begin
            line_level = parity;
          end else if (nxt == LastEdge) begin
            line_level = 1'b1;
          end else if (nxt == WrapEdge) begin
            line_level = 1'b1;
            sending    = 1'b0;
            r.tx_done  = 1'b1;
          end
        end
      end
      r.data_drive   = line_level;
      r.transmitting = sending;
      outcomes.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (outcomes.size() == 0) begin
        $error("result transfer with nothing outstanding: %h", got);
        mismatches++;
        return;
      end
      want = outcomes.pop_front();
      results_seen++;
      if (want.byte_valid) bytes_seen++;
      if (want.tx_done) sends_done++;
      if (got.data_drive !== want.data_drive) begin
        $error("data_drive: expected %0d, got %0d", want.data_drive, got.data_drive);
        mismatches++;
      end
      if (got.byte_valid !== want.byte_valid) begin
        $error("byte_valid: expected %0d, got %0d", want.byte_valid, got.byte_valid);
        mismatches++;
      end
      if (got.rx_byte !== want.rx_byte) begin
        $error("rx_byte: expected %h, got %h", want.rx_byte, got.rx_byte);
        mismatches++;
      end
      if (got.tx_done !== want.tx_done) begin
        $error("tx_done: expected %0d, got %0d", want.tx_done, got.tx_done);
        mismatches++;
      end
      if (got.transmitting !== want.transmitting) begin
        $error("transmitting: expected %0d, got %0d", want.transmitting,
               got.transmitting);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return outcomes.size();
    endfunction
  endclass

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_ready_o;
  logic  mode_i;
  logic  data_bit_i;
  byte_t command_i;
  logic  out_valid_o;
  logic  out_ready_i;
  logic  data_drive_o;
  logic  byte_valid_o;
  byte_t rx_byte_o;
  logic  tx_done_o;
  logic  transmitting_o;

  bit_engine_tracker tracker;
  int unsigned       items_sent;
  int unsigned       cycle_count;
  bit                quiet;          // no idling on either side near the end
  bit                send_jitter;
  bit                long_hold_req;  // asks the receiver for one long stall

  ps2_host_bit_engine_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .data_bit_i    (data_bit_i),
    .command_i     (command_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_drive_o  (data_drive_o),
    .byte_valid_o  (byte_valid_o),
    .rx_byte_o     (rx_byte_o),
    .tx_done_o     (tx_done_o),
    .transmitting_o(transmitting_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // The run is cut off if the block stops making progress.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still outstanding",
               cycle_count, tracker.pending());
      $display("tb: failure");
      $finish;
    end
  end

  // Both monitors sample at the rising edge, before the block's own updates
  // land, so each sees the values that were present during the transfer.
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        tracker.note_transfer(mode_i, data_bit_i, command_i);
      end
      if (out_valid_o && out_ready_i) begin
        got.data_drive   = data_drive_o;
        got.byte_valid   = byte_valid_o;
        got.rx_byte      = rx_byte_o;
        got.tx_done      = tx_done_o;
        got.transmitting = transmitting_o;
        tracker.check_result(got);
      end
    end
  end

  // Result side. Stalls come in short bursts while jitter is on, jitter is
  // switched on and off in windows so that calm stretches also occur, and
  // one long hold lets the block back up until it refuses new transfers.
  initial begin
    int unsigned stall_left;
    int unsigned window;
    bit          jitter;
    stall_left = 0;
    window     = 0;
    jitter     = 1'b1;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      window++;
      if (window % 64 == 0) jitter = ($urandom_range(0, 3) != 0);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i  <= 1'b0;
        stall_left    = LongHold - 1;
      end else if (!quiet && jitter && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall_left   = $urandom_range(1, 3) - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offers one item and returns once it has been transferred. An optional
  // idle gap goes in front of the item, never while an item is on offer.
  task automatic push_item(logic mode, logic data_bit, byte_t command);
    if (items_sent % 40 == 0) send_jitter = ($urandom_range(0, 3) != 0);
    if (items_sent >= QuietItems) quiet = 1'b1;
    @(negedge clk_i);
    if (!quiet && send_jitter && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    data_bit_i <= data_bit;
    command_i  <= command;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    items_sent++;
  endtask

  // Line level a device puts out on a given edge of a frame: start bit, eight
  // data bits LSB first, parity (optionally corrupted), stop bit.
  function automatic logic device_bit(byte_t value, int unsigned k, bit bad_parity);
    if (k == 1) return 1'b0;
    if (k <= 9) return value[k-2];
    if (k == 10) return bit_engine_tracker::odd_of(value) ^ bad_parity;
    return 1'b1;
  endfunction

  // The first `edges` clock edges of a frame coming from the device. The
  // command field carries noise because the block should not look at it.
  task automatic rx_frame(byte_t value, int unsigned edges, bit bad_parity);
    for (int unsigned k = 1; k <= edges; k++) begin
      push_item(ModeEdge, device_bit(value, k, bad_parity), byte_t'($urandom));
    end
  endtask

  // A send request followed by `edges` clock edges. The sampled data level
  // does not matter while transmitting, so it is random.
  task automatic tx_frame(byte_t command, int unsigned edges);
    push_item(ModeSend, 1'($urandom), command);
    for (int unsigned k = 1; k <= edges; k++) begin
      push_item(ModeEdge, 1'($urandom), byte_t'($urandom));
    end
  endtask

  initial begin
    int unsigned pick;
    tracker       = new();
    items_sent    = 0;
    cycle_count   = 0;
    quiet         = 1'b0;
    send_jitter   = 1'b1;
    long_hold_req = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    mode_i        = ModeEdge;
    data_bit_i    = 1'b0;
    command_i     = '0;
    out_ready_i   = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: a complete received frame of all ones, a receive cut
    // short by a send request of all zeros, a transmit restarted by a send
    // of all ones, and that transmit carried through to its stop bit.
    rx_frame(8'hFF, FrameEdges, 1'b0);
    rx_frame(8'h00, 2, 1'b0);
    tx_frame(8'h00, 3);
    tx_frame(8'hFF, FrameEdges);

    // Random part. Most traffic is complete frames in both directions with
    // random content; the rest is frames broken off by a new send request
    // and loose items.
    long_hold_req = 1'b1;
    while (items_sent < TargetItems) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        rx_frame(byte_t'($urandom), FrameEdges, ($urandom_range(0, 3) == 0));
      end else if (pick < 8) begin
        tx_frame(byte_t'($urandom), FrameEdges);
      end else if (pick == 8) begin
        rx_frame(byte_t'($urandom), $urandom_range(0, 10), 1'b0);
        tx_frame(byte_t'($urandom), $urandom_range(0, 10));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          push_item(($urandom_range(0, 3) == 0) ? ModeSend : ModeEdge,
                    1'($urandom), byte_t'($urandom));
        end
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain the outstanding results, then give the pipeline a few more cycles
    // to show any result that should not be there.
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("run covered %0d transfers in, %0d results checked over %0d cycles",
             items_sent, tracker.results_seen, cycle_count);
    $display("frames received from device: %0d, commands sent to device: %0d",
             tracker.bytes_seen, tracker.sends_done);
    if (tracker.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/ps2hbe_pkg.sv
hdl/ps2hbe_in_stage.sv
hdl/ps2hbe_core.sv
hdl/ps2hbe_out_stage.sv
hdl/ps2_host_bit_engine_unit.sv
tb/ps2_host_bit_engine_unit_test.sv
